>>> rtl/gvn_pkg.sv
// Shared types, field layout, register codes and the sine table generator
// for the GNSS velocity to NED filter. No dependencies.
package gvn_pkg;

  localparam int QUAL_W   = 4;
  localparam int SATS_W   = 7;
  localparam int SPEED_W  = 32;
  localparam int COURSE_W = 25;
  localparam int POS_W    = 48;
  localparam int VEL_W    = 32;
  localparam int RATE_W   = 7;
  localparam int MAG_W    = 17;

  localparam int OFS_SATS   = QUAL_W;
  localparam int OFS_SPEED  = OFS_SATS + SATS_W;
  localparam int OFS_COURSE = OFS_SPEED + SPEED_W;
  localparam int OFS_POS    = OFS_COURSE + COURSE_W;
  localparam int IN_BITS    = OFS_POS + POS_W;
  localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = 3 * VEL_W;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REQ_QUALITY = 2'd0,
    CFG_MIN_SATS    = 2'd1,
    CFG_UPDATE_RATE = 2'd2
  } cfg_idx_e;

  localparam logic [QUAL_W-1:0] REQ_QUALITY_RST = 4'd4;
  localparam logic [SATS_W-1:0] MIN_SATS_RST    = 7'd4;
  localparam logic [RATE_W-1:0] UPDATE_RATE_RST = 7'd10;

  // 180 degrees in Q16, rounding offset of the course to phase conversion
  localparam int HALF_CIRCLE_Q16 = 180 * 65536;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // load strobes of pipeline registers 1..6
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
    logic s6;
  } stage_ld_t;

  // sin(x), x in Q30 radians, Taylor series to x^15, result in Q1.16
  function automatic logic [MAG_W-1:0] sine_q16(input logic [63:0] x);
    logic [63:0]        x2;
    logic [63:0]        t;
    logic signed [63:0] s;
    logic [63:0]        v;
    x2 = (x * x + 64'd536870912) >> 30;
    t  = x;
    s  = $signed(x);
    t  = ((t * x2) >> 30) / 64'd6;
    s  = s - $signed(t);
    t  = ((t * x2) >> 30) / 64'd20;
    s  = s + $signed(t);
    t  = ((t * x2) >> 30) / 64'd42;
    s  = s - $signed(t);
    t  = ((t * x2) >> 30) / 64'd72;
    s  = s + $signed(t);
    t  = ((t * x2) >> 30) / 64'd110;
    s  = s - $signed(t);
    t  = ((t * x2) >> 30) / 64'd156;
    s  = s + $signed(t);
    t  = ((t * x2) >> 30) / 64'd210;
    s  = s - $signed(t);
    if (s < 0) begin
      s = '0;
    end
    v = ($unsigned(s) + 64'd8192) >> 14;
    if (v > 64'd65536) begin
      v = 64'd65536;
    end
    return v[MAG_W-1:0];
  endfunction

endpackage

>>> rtl/gvn_trig.sv
// Horizontal path: course to quarter-wave phase, sine ROM, speed scaling.
// Depends on gvn_pkg.
module gvn_trig
  import gvn_pkg::*;
#(
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic                    clk_i,
  input  stage_ld_t               ld_i,
  input  logic [SPEED_W-1:0]      speed_i,
  input  logic [COURSE_W-1:0]     course_i,
  output logic [VEL_W-1:0]        north_o,
  output logic [VEL_W-1:0]        east_o
);

  localparam int DEPTH  = SINE_TABLE_DEPTH;
  localparam int CIRCLE = 4 * DEPTH;
  localparam int CW     = COURSE_W + $clog2(CIRCLE) + 1;
  localparam int XW     = CW - 16;
  localparam int YW     = XW - 3;
  localparam int SH     = YW + 6;
  localparam int RW     = SH - 4;
  localparam longint unsigned RECIP_L = ((64'd1 << SH) + 64'd44) / 64'd45;
  localparam logic [RW-1:0] RECIP = RECIP_L[RW-1:0];
  localparam int PHW    = $clog2(8 * DEPTH);
  localparam int AW     = $clog2(DEPTH + 1);
  localparam int PW     = YW + RW;
  localparam int SPW    = SPEED_W + MAG_W;

  function automatic logic [VEL_W-1:0] round_sat(input logic [SPW-1:0] p, input logic neg);
    logic [SPW-1:0]    r;
    logic [SPW-17:0]   m;
    logic [VEL_W-1:0]  res;
    r = p + SPW'(32768);
    m = r[SPW-1:16];
    if (neg) begin
      if (m >= (SPW-16)'(64'h8000_0000)) begin
        res = {1'b1, {(VEL_W-1){1'b0}}};
      end else begin
        res = -m[VEL_W-1:0];
      end
    end else begin
      if (m > (SPW-16)'(64'h7FFF_FFFF)) begin
        res = {1'b0, {(VEL_W-1){1'b1}}};
      end else begin
        res = m[VEL_W-1:0];
      end
    end
    return res;
  endfunction

  // sine table, sin(k * 90deg / DEPTH)
  logic [MAG_W-1:0] sine_rom [DEPTH+1];
  for (genvar k = 0; k <= DEPTH; k++) begin : g_rom
    localparam logic [63:0] ANGLE = (64'(k) * HALF_PI_Q30) / DEPTH;
    assign sine_rom[k] = sine_q16(ANGLE);
  end

  // stage 1: scaled course
  logic [CW-1:0]      num;
  logic [XW-1:0]      x1_q;
  logic [SPEED_W-1:0] sp1_q;

  assign num = CW'(course_i) * CW'(CIRCLE) + CW'(HALF_CIRCLE_Q16);

  always_ff @(posedge clk_i) begin
    if (ld_i.s1) begin
      x1_q  <= num[CW-1:16];
      sp1_q <= speed_i;
    end
  end

  // stage 2: divide by 360 (shift by 3, reciprocal of 45)
  logic [PW-1:0]      prod2;
  logic [PHW-1:0]     ph2_q;
  logic [SPEED_W-1:0] sp2_q;

  assign prod2 = PW'(x1_q[XW-1:3]) * PW'(RECIP);

  always_ff @(posedge clk_i) begin
    if (ld_i.s2) begin
      ph2_q <= prod2[SH +: PHW];
      sp2_q <= sp1_q;
    end
  end

  // stage 3: wrap and split into quadrant and offset
  logic [PHW-1:0]     ph_w;
  logic [PHW-1:0]     rem;
  logic [1:0]         quad;
  logic [1:0]         quad3_q;
  logic [AW-1:0]      rem3_q;
  logic [SPEED_W-1:0] sp3_q;

  always_comb begin
    ph_w = (ph2_q >= PHW'(CIRCLE)) ? ph2_q - PHW'(CIRCLE) : ph2_q;
    priority if (ph_w >= PHW'(3 * DEPTH)) begin
      quad = 2'd3;
      rem  = ph_w - PHW'(3 * DEPTH);
    end else if (ph_w >= PHW'(2 * DEPTH)) begin
      quad = 2'd2;
      rem  = ph_w - PHW'(2 * DEPTH);
    end else if (ph_w >= PHW'(DEPTH)) begin
      quad = 2'd1;
      rem  = ph_w - PHW'(DEPTH);
    end else begin
      quad = 2'd0;
      rem  = ph_w;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i.s3) begin
      quad3_q <= quad;
      rem3_q  <= rem[AW-1:0];
      sp3_q   <= sp2_q;
    end
  end

  // stage 4: ROM read
  logic [AW-1:0]      idx_lo;
  logic [AW-1:0]      idx_hi;
  logic [MAG_W-1:0]   smag4_q;
  logic [MAG_W-1:0]   cmag4_q;
  logic               sneg4_q;
  logic               cneg4_q;
  logic [SPEED_W-1:0] sp4_q;

  assign idx_lo = rem3_q;
  assign idx_hi = AW'(DEPTH) - rem3_q;

  always_ff @(posedge clk_i) begin
    if (ld_i.s4) begin
      smag4_q <= sine_rom[quad3_q[0] ? idx_hi : idx_lo];
      cmag4_q <= sine_rom[quad3_q[0] ? idx_lo : idx_hi];
      sneg4_q <= quad3_q[1];
      cneg4_q <= quad3_q[1] ^ quad3_q[0];
      sp4_q   <= sp3_q;
    end
  end

  // stage 5: speed products
  logic [SPW-1:0] ps5_q;
  logic [SPW-1:0] pc5_q;
  logic           sneg5_q;
  logic           cneg5_q;

  always_ff @(posedge clk_i) begin
    if (ld_i.s5) begin
      ps5_q   <= SPW'(sp4_q) * SPW'(smag4_q);
      pc5_q   <= SPW'(sp4_q) * SPW'(cmag4_q);
      sneg5_q <= sneg4_q;
      cneg5_q <= cneg4_q;
    end
  end

  // stage 6: round, sign, saturate
  always_ff @(posedge clk_i) begin
    if (ld_i.s6) begin
      north_o <= round_sat(pc5_q, cneg5_q);
      east_o  <= round_sat(ps5_q, sneg5_q);
    end
  end

endmodule

>>> rtl/gvn_down.sv
// Down path: position difference times update rate, moving-average window,
// held value on satellite count change. Depends on gvn_pkg.
module gvn_down
  import gvn_pkg::*;
#(
  parameter int WINDOW_LENGTH = 4
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  stage_ld_t                ld_i,
  input  logic [SATS_W-1:0]        sats_i,
  input  logic signed [POS_W-1:0]  pos_i,
  input  logic [RATE_W-1:0]        rate_i,
  output logic [VEL_W-1:0]         down_o,
  output logic                     fresh_o
);

  localparam int LW   = $clog2(WINDOW_LENGTH);
  localparam int SW   = VEL_W + LW;
  localparam int SH   = SW + LW;
  localparam int DW   = POS_W + 1;
  localparam int RPW  = DW + RATE_W + 1;
  localparam int LO_W = 18;
  localparam int HI_W = SW - LO_W;
  localparam int TW   = 2 * SW + 1;
  localparam longint unsigned RCP_L =
    ((64'd1 << SH) + 64'(WINDOW_LENGTH) - 64'd1) / WINDOW_LENGTH;
  localparam logic [SW:0] RCP = RCP_L[SW:0];
  localparam logic [SW-1:0] HALF_W = SW'(WINDOW_LENGTH / 2);

  // stage 1: track previous fix, position difference
  logic signed [POS_W-1:0] prev_pos_q;
  logic [SATS_W-1:0]       prev_sats_q;
  logic signed [DW-1:0]    diff1_q;
  logic                    fresh1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_pos_q  <= '0;
      prev_sats_q <= '0;
    end else if (ld_i.s1) begin
      prev_pos_q  <= pos_i;
      prev_sats_q <= sats_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i.s1) begin
      fresh1_q <= (sats_i == prev_sats_q);
      diff1_q  <= DW'(pos_i) - DW'(prev_pos_q);
    end
  end

  // stage 2: scale by update rate, saturate
  logic signed [RPW-1:0]   rate_full;
  logic signed [VEL_W-1:0] rate_sat;
  logic signed [VEL_W-1:0] rate2_q;
  logic                    fresh2_q;

  assign rate_full = RPW'(diff1_q) * $signed({1'b0, rate_i});

  always_comb begin
    if ((rate_full[RPW-1:VEL_W-1] == '0) || (rate_full[RPW-1:VEL_W-1] == '1)) begin
      rate_sat = rate_full[VEL_W-1:0];
    end else if (rate_full[RPW-1]) begin
      rate_sat = {1'b1, {(VEL_W-1){1'b0}}};
    end else begin
      rate_sat = {1'b0, {(VEL_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i.s2) begin
      rate2_q  <= rate_sat;
      fresh2_q <= fresh1_q;
    end
  end

  // stage 3: window shift with running sum
  logic signed [VEL_W-1:0] win_q [WINDOW_LENGTH];
  logic signed [SW-1:0]    sum_q;
  logic signed [SW-1:0]    sum_d;
  logic signed [SW-1:0]    sum3_q;
  logic                    fresh3_q;

  assign sum_d = sum_q + SW'(rate2_q) - SW'(win_q[WINDOW_LENGTH-1]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WINDOW_LENGTH; i++) begin
        win_q[i] <= '0;
      end
      sum_q <= '0;
    end else if (ld_i.s3 && fresh2_q) begin
      win_q[0] <= rate2_q;
      for (int i = 1; i < WINDOW_LENGTH; i++) begin
        win_q[i] <= win_q[i-1];
      end
      sum_q <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i.s3) begin
      sum3_q   <= sum_d;
      fresh3_q <= fresh2_q;
    end
  end

  // stage 4: magnitude plus half window for rounding
  logic [SW-1:0] mag_abs;
  logic [SW-1:0] mag4_q;
  logic          neg4_q;
  logic          fresh4_q;

  assign mag_abs = sum3_q[SW-1] ? SW'(-sum3_q) : SW'(sum3_q);

  always_ff @(posedge clk_i) begin
    if (ld_i.s4) begin
      mag4_q   <= mag_abs + HALF_W;
      neg4_q   <= sum3_q[SW-1];
      fresh4_q <= fresh3_q;
    end
  end

  // stage 5: reciprocal partial products
  logic [LO_W+SW:0] plo5_q;
  logic [HI_W+SW:0] phi5_q;
  logic             neg5_q;
  logic             fresh5_q;

  always_ff @(posedge clk_i) begin
    if (ld_i.s5) begin
      plo5_q   <= (LO_W+SW+1)'(mag4_q[LO_W-1:0]) * (LO_W+SW+1)'(RCP);
      phi5_q   <= (HI_W+SW+1)'(mag4_q[SW-1:LO_W]) * (HI_W+SW+1)'(RCP);
      neg5_q   <= neg4_q;
      fresh5_q <= fresh4_q;
    end
  end

  // stage 6: quotient, sign, held value
  logic [TW-1:0]     total;
  logic [VEL_W-1:0]  quo;
  logic [VEL_W-1:0]  down_val;
  logic [VEL_W-1:0]  held_q;

  assign total    = (TW'(phi5_q) << LO_W) + TW'(plo5_q);
  assign quo      = total[SH +: VEL_W];
  assign down_val = neg5_q ? -quo : quo;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
    end else if (ld_i.s6 && fresh5_q) begin
      held_q <= down_val;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i.s6) begin
      down_o  <= fresh5_q ? down_val : held_q;
      fresh_o <= fresh5_q;
    end
  end

  a_held_repeat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ld_i.s6 && !fresh5_q) |=> (down_o == $past(held_q)))
    else $error("held down velocity not repeated");

  a_held_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ld_i.s6 && fresh5_q) |=> (held_q == down_o))
    else $error("held down velocity out of step with output");

  a_sum_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ld_i.s3 && !fresh2_q) |=> $stable(sum_q))
    else $error("window sum moved on restarted fix");

endmodule

>>> rtl/gnss_velocity_to_ned_filter.sv
// Throughput: one fix per cycle; an input register and six pipeline stages,
// with ready falling only when every stage is full and the output is stalled.
// Rejected fixes (quality or satellite count) are dropped at the input register.
// Reset: async active low; registers to defaults, history and window to zero.
// Depends on gvn_pkg, gvn_trig, gvn_down.
module gnss_velocity_to_ned_filter
  import gvn_pkg::*;
#(
  parameter int WINDOW_LENGTH    = 4,
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // fix_quality, satellite_count, ground_speed, course_angle, down_position, pad
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // north_velocity, east_velocity, down_velocity
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // down_fresh
  output logic                   m_axis_tuser
);

  localparam int NSTG = 7;

  logic [QUAL_W-1:0] req_quality_q;
  logic [SATS_W-1:0] min_sats_q;
  logic [RATE_W-1:0] update_rate_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_quality_q <= REQ_QUALITY_RST;
      min_sats_q    <= MIN_SATS_RST;
      update_rate_q <= UPDATE_RATE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_REQ_QUALITY: req_quality_q <= cfg_data_i[QUAL_W-1:0];
        CFG_MIN_SATS:    min_sats_q    <= cfg_data_i[SATS_W-1:0];
        CFG_UPDATE_RATE: update_rate_q <= cfg_data_i[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  logic [QUAL_W-1:0]   in_quality;
  logic [SATS_W-1:0]   in_sats;
  logic                fix_ok;

  assign in_quality = s_axis_tdata[QUAL_W-1:0];
  assign in_sats    = s_axis_tdata[OFS_SATS +: SATS_W];
  assign fix_ok     = (in_quality == req_quality_q) && (in_sats >= min_sats_q);

  // valid per stage, ready ripples back from the output
  logic [NSTG-1:0] v_q;
  logic [NSTG:0]   rdy;
  stage_ld_t       ld;

  assign rdy[NSTG] = m_axis_tready;
  for (genvar k = 0; k < NSTG; k++) begin : g_rdy
    assign rdy[k] = !v_q[k] || rdy[k+1];
  end

  assign s_axis_tready = rdy[0];
  assign ld.s1 = v_q[0] && rdy[1];
  assign ld.s2 = v_q[1] && rdy[2];
  assign ld.s3 = v_q[2] && rdy[3];
  assign ld.s4 = v_q[3] && rdy[4];
  assign ld.s5 = v_q[4] && rdy[5];
  assign ld.s6 = v_q[5] && rdy[6];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) begin
        v_q[0] <= s_axis_tvalid && fix_ok;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // input register
  logic [SATS_W-1:0]       sats0_q;
  logic [SPEED_W-1:0]      speed0_q;
  logic [COURSE_W-1:0]     course0_q;
  logic signed [POS_W-1:0] pos0_q;

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && rdy[0]) begin
      sats0_q   <= in_sats;
      speed0_q  <= s_axis_tdata[OFS_SPEED +: SPEED_W];
      course0_q <= s_axis_tdata[OFS_COURSE +: COURSE_W];
      pos0_q    <= s_axis_tdata[OFS_POS +: POS_W];
    end
  end

  logic [VEL_W-1:0] north;
  logic [VEL_W-1:0] east;
  logic [VEL_W-1:0] down;
  logic             fresh;

  gvn_trig #(
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
  ) u_trig (
    .clk_i    (clk_i),
    .ld_i     (ld),
    .speed_i  (speed0_q),
    .course_i (course0_q),
    .north_o  (north),
    .east_o   (east)
  );

  gvn_down #(
    .WINDOW_LENGTH(WINDOW_LENGTH)
  ) u_down (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ld_i    (ld),
    .sats_i  (sats0_q),
    .pos_i   (pos0_q),
    .rate_i  (update_rate_q),
    .down_o  (down),
    .fresh_o (fresh)
  );

  assign m_axis_tvalid = v_q[NSTG-1];
  assign m_axis_tdata  = {down, east, north};
  assign m_axis_tuser  = fresh;

  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output drains");

  a_reject_dropped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && !fix_ok) |=> !v_q[0])
    else $error("rejected fix entered the pipeline");

endmodule
